### rtl/rccc_pkg.sv
// Shared types, codes and constants of the drum cleaning-cycle controller.
// Used by the front queue, the back sequencer and the top level.
package rccc_pkg;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_CYCLE  = 3'd1;
    localparam logic [2:0] ACT_EMPTY  = 3'd2;
    localparam logic [2:0] ACT_RESET  = 3'd3;
    localparam logic [2:0] ACT_HOME   = 3'd4;
    localparam logic [2:0] ACT_PAUSE  = 3'd5;
    localparam logic [2:0] ACT_RESUME = 3'd6;
    localparam logic [2:0] ACT_BOOT   = 3'd7;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CAT    = 4'd1;
    localparam logic [3:0] S_WAIT   = 4'd2;
    localparam logic [3:0] S_CCW    = 4'd3;
    localparam logic [3:0] S_DPAUSE = 4'd4;
    localparam logic [3:0] S_CW     = 4'd5;
    localparam logic [3:0] S_LOVER  = 4'd6;
    localparam logic [3:0] S_LRET   = 4'd7;
    localparam logic [3:0] S_LBOVER = 4'd8;
    localparam logic [3:0] S_LBRET  = 4'd9;
    localparam logic [3:0] S_EMPTY  = 4'd10;
    localparam logic [3:0] S_EPAUSE = 4'd11;
    localparam logic [3:0] S_RESET  = 4'd12;
    localparam logic [3:0] S_BOOT   = 4'd13;
    localparam logic [3:0] S_PAUSED = 4'd14;
    localparam logic [3:0] S_ERROR  = 4'd15;

    localparam logic [1:0] D_STOP = 2'd0;
    localparam logic [1:0] D_CCW  = 2'd1;
    localparam logic [1:0] D_CW   = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_WDOG   = 2'd1;
    localparam logic [1:0] ERR_PINCH  = 2'd2;
    localparam logic [1:0] ERR_MANUAL = 2'd3;

    localparam logic [2:0] Z_SAFE    = 3'd0;
    localparam logic [2:0] Z_OUT     = 3'd1;
    localparam logic [2:0] Z_DUMP    = 3'd2;
    localparam logic [2:0] Z_RETURN  = 3'd3;
    localparam logic [2:0] Z_PAST_CW = 3'd4;
    localparam logic [2:0] Z_PAST_CC = 3'd5;
    localparam logic [2:0] Z_UNKNOWN = 3'd6;

    localparam logic [2:0] CFG_TIMEOUT  = 3'd0;
    localparam logic [2:0] CFG_CAT_MIN  = 3'd1;
    localparam logic [2:0] CFG_WAIT_MIN = 3'd2;
    localparam logic [2:0] CFG_DUMP     = 3'd3;
    localparam logic [2:0] CFG_LEVEL    = 3'd4;
    localparam logic [2:0] CFG_EPAUSE   = 3'd5;
    localparam logic [2:0] CFG_WEIGHT   = 3'd6;
    localparam logic [2:0] CFG_PRES     = 3'd7;

    localparam logic [9:0]  MS_PER_SEC = 10'd1000;
    localparam logic [15:0] MS_PER_MIN = 16'd60000;
    localparam logic [31:0] RESET_KICK_MS = 32'd1000;

    // Rounded-up 2^38 / 1000; the product shifted right by 38 is the exact
    // quotient by 1000 for every 32-bit dividend.
    localparam logic [28:0] MS_RECIP       = 29'd274877907;
    localparam int          MS_RECIP_SHIFT = 38;

    // One queued input item, with the combined presence sense added.
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_ms;
        logic        cat_switch;
        logic        cat_on_scale;
        logic        presence_seen;
        logic        at_home;
        logic        at_dump;
        logic [2:0]  saved_zone;
        logic        sense_any;
    } rccc_item_t;

    function automatic logic [2:0] zone_of(input logic [3:0] s);
        logic [2:0] z;
        case (s)
            S_CCW, S_EMPTY:     z = Z_OUT;
            S_DPAUSE, S_EPAUSE: z = Z_DUMP;
            S_CW:               z = Z_RETURN;
            S_LOVER, S_LRET:    z = Z_PAST_CW;
            S_LBOVER, S_LBRET:  z = Z_PAST_CC;
            S_RESET, S_BOOT:    z = Z_UNKNOWN;
            default:            z = Z_SAFE;
        endcase
        return z;
    endfunction

endpackage

### rtl/rotary_cleaning_cycle_controller.sv
// Top level of the drum cleaning-cycle controller: front queue and back sequencer.
// Depends on rccc_pkg, rccc_front and rccc_back.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_stall   | action, now_ms, sensor bits, saved_zone
//  result   | out_valid / out_stall | machine_state ... cycle_duration_sec
//  config   | cfg_we                | cfg_index, cfg_data
//
// An item that does not finish a cleaning cycle passes through the sequencer into
// the result register; one that finishes a cycle then goes through the product
// register of the reciprocal divide by 1000 of the duration before it is valid.
// A four-entry queue accepts items while the result waits on out_stall, until full.
// Reset is asynchronous and active low; it restores control but not data registers.
module rotary_cleaning_cycle_controller #(
    parameter int BACK_OVERSHOOT_SEC = 2,
    parameter int MANUAL_RESUME_SEC  = 60,
    parameter int PINCH_RESUME_SEC   = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [31:0] now_ms,
    input  logic        cat_switch,
    input  logic        cat_on_scale,
    input  logic        presence_seen,
    input  logic        at_home,
    input  logic        at_dump,
    input  logic [2:0]  saved_zone,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  machine_state,
    output logic [1:0]  motor_drive,
    output logic        request_accepted,
    output logic        zone_write,
    output logic [2:0]  zone_value,
    output logic [1:0]  error_code,
    output logic        cycle_done,
    output logic [15:0] cycle_duration_sec
);
    import rccc_pkg::*;

    rccc_item_t item;
    logic       item_avail, pop;

    rccc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .now_ms        (now_ms),
        .cat_switch    (cat_switch),
        .cat_on_scale  (cat_on_scale),
        .presence_seen (presence_seen),
        .at_home       (at_home),
        .at_dump       (at_dump),
        .saved_zone    (saved_zone),
        .pop           (pop),
        .item_avail    (item_avail),
        .item          (item)
    );

    rccc_back #(
        .BACK_OVERSHOOT_SEC (BACK_OVERSHOOT_SEC),
        .MANUAL_RESUME_SEC  (MANUAL_RESUME_SEC),
        .PINCH_RESUME_SEC   (PINCH_RESUME_SEC)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .item_avail         (item_avail),
        .item               (item),
        .pop                (pop),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .machine_state      (machine_state),
        .motor_drive        (motor_drive),
        .request_accepted   (request_accepted),
        .zone_write         (zone_write),
        .zone_value         (zone_value),
        .error_code         (error_code),
        .cycle_done         (cycle_done),
        .cycle_duration_sec (cycle_duration_sec)
    );

endmodule

### rtl/rccc_front.sv
// Front part: accepts input items, adds the presence summary and queues them.
// Depends on rccc_pkg for the item type.
module rccc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          action,
    input  logic [31:0]         now_ms,
    input  logic                cat_switch,
    input  logic                cat_on_scale,
    input  logic                presence_seen,
    input  logic                at_home,
    input  logic                at_dump,
    input  logic [2:0]          saved_zone,
    input  logic                pop,
    output logic                item_avail,
    output rccc_pkg::rccc_item_t item
);
    import rccc_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW = $clog2(DEPTH);

    rccc_item_t     mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]    count_reg;
    logic           push;
    rccc_item_t     w_item;

    assign in_stall   = (count_reg == (AW+1)'(DEPTH));
    assign push       = in_valid && !in_stall;
    assign item_avail = (count_reg != '0);
    assign item       = mem[rd_ptr_reg];

    always_comb
    begin
        w_item.action        = action;
        w_item.now_ms        = now_ms;
        w_item.cat_switch    = cat_switch;
        w_item.cat_on_scale  = cat_on_scale;
        w_item.presence_seen = presence_seen;
        w_item.at_home       = at_home;
        w_item.at_dump       = at_dump;
        w_item.saved_zone    = saved_zone;
        w_item.sense_any     = cat_switch | cat_on_scale | presence_seen;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= w_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/rccc_back.sv
// Back part: configuration registers, the sixteen-state sequencer, a reciprocal
// divide by 1000 for cycle duration, and the result register. Uses rccc_pkg.
module rccc_back #(
    parameter int BACK_OVERSHOOT_SEC = 2,
    parameter int MANUAL_RESUME_SEC  = 60,
    parameter int PINCH_RESUME_SEC   = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 item_avail,
    input  rccc_pkg::rccc_item_t item,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [3:0]           machine_state,
    output logic [1:0]           motor_drive,
    output logic                 request_accepted,
    output logic                 zone_write,
    output logic [2:0]           zone_value,
    output logic [1:0]           error_code,
    output logic                 cycle_done,
    output logic [15:0]          cycle_duration_sec
);
    import rccc_pkg::*;

    localparam logic [31:0] BACK_MS   = 32'(BACK_OVERSHOOT_SEC * 1000);
    localparam logic [31:0] MANUAL_MS = 32'(MANUAL_RESUME_SEC * 1000);
    localparam logic [31:0] PINCH_MS  = 32'(PINCH_RESUME_SEC * 1000);

    localparam logic PH_RUN = 1'b0;
    localparam logic PH_DIV = 1'b1;

    // Configuration registers and their millisecond limits.
    logic [15:0] timeout_reg;
    logic [7:0]  cat_min_reg, wait_min_reg, dump_reg, level_reg, epause_reg;
    logic        weight_reg, pres_reg;
    logic [25:0] wd_ms_reg;
    logic [23:0] cat_ms_reg, wait_ms_reg;
    logic [17:0] dump_ms_reg, level_ms_reg, epause_ms_reg;

    // Controller state.
    logic [3:0]  cur_reg, pf_reg;
    logic [31:0] phase_reg, cbegin_reg, timed_reg, center_reg, cleft_reg, pstart_reg;
    logic        armed_reg, manual_reg, resetting_reg;
    logic [2:0]  lz_reg;
    logic [1:0]  drive_reg, err_reg;

    logic [3:0]  cur_next, pf_next;
    logic [31:0] phase_next, cbegin_next, timed_next, center_next, cleft_next, pstart_next;
    logic        armed_next, manual_next, resetting_next;
    logic [2:0]  lz_next;
    logic [1:0]  drive_next, err_next;

    logic        ok, zw, done, do_resume, still;
    logic [3:0]  base_state;
    logic [2:0]  base_lz, boot_lz, new_zone;
    logic [31:0] now, grace, dur_ms;

    // Sequencer phase, divider and result registers.
    logic        phase_mode_reg;
    logic        div_cnt_reg;
    logic [31:0] div_q_reg;
    logic [60:0] prod_reg;
    logic        out_free, exec;

    logic        ov_reg;
    logic [3:0]  o_state_reg;
    logic [1:0]  o_drive_reg, o_err_reg;
    logic        o_ok_reg, o_zw_reg, o_done_reg;
    logic [2:0]  o_zone_reg;
    logic [15:0] o_dur_reg;

    assign out_free = !ov_reg || !out_stall;
    assign exec     = (phase_mode_reg == PH_RUN) && item_avail && out_free;
    assign pop      = exec;
    assign now      = item.now_ms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= 16'd120;
            cat_min_reg  <= 8'd30;
            wait_min_reg <= 8'd7;
            dump_reg     <= 8'd5;
            level_reg    <= 8'd2;
            epause_reg   <= 8'd30;
            weight_reg   <= 1'b0;
            pres_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                CFG_CAT_MIN:  cat_min_reg  <= cfg_data[7:0];
                CFG_WAIT_MIN: wait_min_reg <= cfg_data[7:0];
                CFG_DUMP:     dump_reg     <= cfg_data[7:0];
                CFG_LEVEL:    level_reg    <= cfg_data[7:0];
                CFG_EPAUSE:   epause_reg   <= cfg_data[7:0];
                CFG_WEIGHT:   weight_reg   <= cfg_data[0];
                CFG_PRES:     pres_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Limits are registered from the configuration registers; an item executes no earlier
    // than the edge after its acceptance, so a write made before it arrives is seen.
    always_ff @(posedge clk)
    begin
        wd_ms_reg     <= 26'(timeout_reg) * 26'(MS_PER_SEC);
        cat_ms_reg    <= 24'(cat_min_reg) * 24'(MS_PER_MIN);
        wait_ms_reg   <= 24'(wait_min_reg) * 24'(MS_PER_MIN);
        dump_ms_reg   <= 18'(dump_reg) * 18'(MS_PER_SEC);
        level_ms_reg  <= 18'(level_reg) * 18'(MS_PER_SEC);
        epause_ms_reg <= 18'(epause_reg) * 18'(MS_PER_SEC);
    end

    always_comb
    begin
        cur_next       = cur_reg;
        pf_next        = pf_reg;
        phase_next     = phase_reg;
        cbegin_next    = cbegin_reg;
        timed_next     = timed_reg;
        center_next    = center_reg;
        cleft_next     = cleft_reg;
        pstart_next    = pstart_reg;
        armed_next     = armed_reg;
        manual_next    = manual_reg;
        resetting_next = resetting_reg;
        drive_next     = drive_reg;
        err_next       = err_reg;
        ok             = 1'b1;
        zw             = 1'b0;
        done           = 1'b0;
        do_resume      = 1'b0;
        base_state     = cur_reg;
        base_lz        = lz_reg;
        boot_lz        = (item.saved_zone > Z_UNKNOWN) ? Z_UNKNOWN : item.saved_zone;
        still          = item.cat_switch | (weight_reg & item.cat_on_scale)
                         | (pres_reg & item.presence_seen);
        grace          = manual_reg ? MANUAL_MS : PINCH_MS;
        dur_ms         = now - cbegin_reg;

        case (item.action)
            ACT_TICK:
            begin
                case (cur_reg)
                    S_IDLE:
                    begin
                        if (item.sense_any)
                        begin
                            center_next = now;
                            cur_next    = S_CAT;
                        end
                    end
                    S_CAT:
                    begin
                        if (!still || (now - center_reg) > 32'(cat_ms_reg))
                        begin
                            cleft_next = now;
                            cur_next   = S_WAIT;
                        end
                    end
                    S_WAIT:
                    begin
                        if (still)
                        begin
                            center_next = now;
                            cur_next    = S_CAT;
                        end
                        else if ((now - cleft_reg) >= 32'(wait_ms_reg))
                        begin
                            resetting_next = 1'b0;
                            drive_next     = D_CCW;
                            cbegin_next    = now;
                            phase_next     = now;
                            cur_next       = S_CCW;
                        end
                    end
                    S_PAUSED:
                    begin
                        if ((now - pstart_reg) >= grace)
                        begin
                            if (!item.cat_switch)
                            begin
                                do_resume = 1'b1;
                            end
                            else
                            begin
                                err_next   = manual_reg ? ERR_MANUAL : ERR_PINCH;
                                drive_next = D_STOP;
                                cur_next   = S_ERROR;
                            end
                        end
                    end
                    S_ERROR:
                    begin
                    end
                    default:
                    begin
                        if ((now - phase_reg) > 32'(wd_ms_reg))
                        begin
                            err_next   = ERR_WDOG;
                            drive_next = D_STOP;
                            cur_next   = S_ERROR;
                        end
                        else if (item.cat_switch)
                        begin
                            // Anti-pinch: stop and remember where we were.
                            drive_next  = D_STOP;
                            pf_next     = cur_reg;
                            pstart_next = now;
                            manual_next = 1'b0;
                            cur_next    = S_PAUSED;
                        end
                        else
                        begin
                            case (cur_reg)
                                S_CCW, S_EMPTY:
                                begin
                                    if (item.at_dump)
                                    begin
                                        drive_next = D_STOP;
                                        timed_next = now;
                                        phase_next = now;
                                        cur_next   = (cur_reg == S_CCW) ? S_DPAUSE : S_EPAUSE;
                                    end
                                end
                                S_DPAUSE:
                                begin
                                    if ((now - timed_reg) >= 32'(dump_ms_reg))
                                    begin
                                        drive_next = D_CW;
                                        phase_next = now;
                                        cur_next   = S_CW;
                                    end
                                end
                                S_CW:
                                begin
                                    if (item.at_home)
                                    begin
                                        if (level_reg == 8'd0)
                                        begin
                                            drive_next     = D_STOP;
                                            done           = !resetting_reg;
                                            resetting_next = 1'b0;
                                            cur_next       = S_IDLE;
                                        end
                                        else
                                        begin
                                            timed_next = now;
                                            phase_next = now;
                                            cur_next   = S_LOVER;
                                        end
                                    end
                                end
                                S_LOVER:
                                begin
                                    if ((now - timed_reg) >= 32'(level_ms_reg))
                                    begin
                                        drive_next = D_CCW;
                                        phase_next = now;
                                        armed_next = 1'b0;
                                        cur_next   = S_LRET;
                                    end
                                end
                                S_LRET:
                                begin
                                    if (!armed_reg)
                                    begin
                                        if (!item.at_home)
                                        begin
                                            armed_next = 1'b1;
                                        end
                                    end
                                    else if (item.at_home)
                                    begin
                                        timed_next = now;
                                        phase_next = now;
                                        cur_next   = S_LBOVER;
                                    end
                                end
                                S_LBOVER:
                                begin
                                    if ((now - timed_reg) >= BACK_MS)
                                    begin
                                        drive_next = D_CW;
                                        phase_next = now;
                                        armed_next = 1'b0;
                                        cur_next   = S_LBRET;
                                    end
                                end
                                S_LBRET:
                                begin
                                    if (!armed_reg)
                                    begin
                                        if (!item.at_home)
                                        begin
                                            armed_next = 1'b1;
                                        end
                                    end
                                    else if (item.at_home)
                                    begin
                                        drive_next     = D_STOP;
                                        done           = !resetting_reg;
                                        resetting_next = 1'b0;
                                        cur_next       = S_IDLE;
                                    end
                                end
                                S_EPAUSE:
                                begin
                                    if ((now - timed_reg) >= 32'(epause_ms_reg))
                                    begin
                                        phase_next = now;
                                        cur_next   = S_RESET;
                                    end
                                end
                                S_RESET:
                                begin
                                    if (item.at_home)
                                    begin
                                        drive_next     = D_STOP;
                                        resetting_next = 1'b0;
                                        cur_next       = S_IDLE;
                                    end
                                    else if ((now - phase_reg) > RESET_KICK_MS)
                                    begin
                                        drive_next = D_CW;
                                    end
                                end
                                S_BOOT:
                                begin
                                    if (item.at_home)
                                    begin
                                        drive_next = D_STOP;
                                        cur_next   = S_IDLE;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                endcase
            end
            ACT_CYCLE, ACT_EMPTY:
            begin
                if (cur_reg != S_IDLE)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    resetting_next = 1'b0;
                    drive_next     = D_CCW;
                    cbegin_next    = now;
                    phase_next     = now;
                    cur_next       = (item.action == ACT_CYCLE) ? S_CCW : S_EMPTY;
                end
            end
            ACT_RESET:
            begin
                drive_next = D_STOP;
                err_next   = ERR_NONE;
                if (!(cur_reg == S_ERROR || cur_reg == S_PAUSED || cur_reg == S_EMPTY ||
                      cur_reg == S_EPAUSE || cur_reg == S_DPAUSE || cur_reg == S_LOVER ||
                      cur_reg == S_LRET || cur_reg == S_LBOVER || cur_reg == S_LBRET ||
                      cur_reg == S_RESET))
                begin
                    ok = 1'b0;
                end
                else if (item.at_home)
                begin
                    resetting_next = 1'b0;
                    cur_next       = S_IDLE;
                end
                else
                begin
                    resetting_next = 1'b1;
                    cbegin_next    = now;
                    phase_next     = now;
                    if (item.at_dump)
                    begin
                        timed_next = now;
                        cur_next   = S_DPAUSE;
                    end
                    else
                    begin
                        drive_next = D_CCW;
                        cur_next   = S_CCW;
                    end
                end
            end
            ACT_HOME:
            begin
                if (cur_reg == S_IDLE)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    drive_next  = D_STOP;
                    err_next    = ERR_NONE;
                    cbegin_next = now;
                    phase_next  = now;
                    if (item.at_home)
                    begin
                        resetting_next = 1'b0;
                        cur_next       = S_IDLE;
                    end
                    else
                    begin
                        resetting_next = 1'b1;
                        drive_next     = D_CW;
                        cur_next       = S_CW;
                    end
                end
            end
            ACT_PAUSE:
            begin
                if (cur_reg < S_CCW || cur_reg > S_BOOT)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    drive_next  = D_STOP;
                    pf_next     = cur_reg;
                    pstart_next = now;
                    manual_next = 1'b1;
                    cur_next    = S_PAUSED;
                end
            end
            ACT_RESUME:
            begin
                if (cur_reg != S_PAUSED)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    do_resume = 1'b1;
                end
            end
            default:
            begin
                // Boot: clear all but configuration, then restart from saved zone.
                base_state     = S_IDLE;
                cur_next       = S_IDLE;
                pf_next        = S_IDLE;
                phase_next     = '0;
                cbegin_next    = '0;
                timed_next     = '0;
                center_next    = '0;
                cleft_next     = '0;
                pstart_next    = '0;
                armed_next     = 1'b0;
                manual_next    = 1'b0;
                resetting_next = 1'b0;
                drive_next     = D_STOP;
                err_next       = ERR_NONE;
                base_lz        = boot_lz;
                if (item.at_home)
                begin
                    zw      = (boot_lz != Z_SAFE);
                    base_lz = Z_SAFE;
                end
                else
                begin
                    phase_next  = now;
                    cbegin_next = now;
                    if (boot_lz >= Z_OUT && boot_lz <= Z_PAST_CC)
                    begin
                        drive_next = (boot_lz == Z_PAST_CW) ? D_CCW : D_CW;
                        cur_next   = S_BOOT;
                    end
                    else
                    begin
                        resetting_next = 1'b1;
                        if (item.at_dump)
                        begin
                            timed_next = now;
                            cur_next   = S_DPAUSE;
                        end
                        else
                        begin
                            drive_next = D_CCW;
                            cur_next   = S_CCW;
                        end
                    end
                end
            end
        endcase

        if (do_resume)
        begin
            phase_next = now;
            case (pf_reg)
                S_CCW, S_EMPTY:     drive_next = D_CCW;
                S_DPAUSE, S_EPAUSE: timed_next = now;
                S_CW, S_RESET:      drive_next = D_CW;
                S_LOVER:
                begin
                    drive_next = D_CW;
                    timed_next = now;
                end
                S_LRET:
                begin
                    drive_next = D_CCW;
                    armed_next = 1'b0;
                end
                S_LBOVER:
                begin
                    drive_next = D_CCW;
                    timed_next = now;
                end
                S_LBRET:
                begin
                    drive_next = D_CW;
                    armed_next = 1'b0;
                end
                default:            ;
            endcase
            cur_next = pf_reg;
        end

        // Apart from boot, the saved zone only follows real state changes.
        new_zone = zone_of(cur_next);
        lz_next  = base_lz;
        if (cur_next != base_state && new_zone != base_lz)
        begin
            lz_next = new_zone;
            zw      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= S_IDLE;
            pf_reg         <= S_IDLE;
            phase_reg      <= '0;
            cbegin_reg     <= '0;
            timed_reg      <= '0;
            center_reg     <= '0;
            cleft_reg      <= '0;
            pstart_reg     <= '0;
            armed_reg      <= 1'b0;
            manual_reg     <= 1'b0;
            resetting_reg  <= 1'b0;
            lz_reg         <= Z_SAFE;
            drive_reg      <= D_STOP;
            err_reg        <= ERR_NONE;
            phase_mode_reg <= PH_RUN;
            div_cnt_reg    <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            if (exec)
            begin
                cur_reg       <= cur_next;
                pf_reg        <= pf_next;
                phase_reg     <= phase_next;
                cbegin_reg    <= cbegin_next;
                timed_reg     <= timed_next;
                center_reg    <= center_next;
                cleft_reg     <= cleft_next;
                pstart_reg    <= pstart_next;
                armed_reg     <= armed_next;
                manual_reg    <= manual_next;
                resetting_reg <= resetting_next;
                lz_reg        <= lz_next;
                drive_reg     <= drive_next;
                err_reg       <= err_next;
                if (done)
                begin
                    phase_mode_reg <= PH_DIV;
                    div_cnt_reg    <= 1'b0;
                end
                else
                begin
                    ov_reg <= 1'b1;
                end
            end
            else if (phase_mode_reg == PH_DIV)
            begin
                if (!div_cnt_reg)
                begin
                    div_cnt_reg <= 1'b1;
                end
                else if (out_free)
                begin
                    phase_mode_reg <= PH_RUN;
                    ov_reg         <= 1'b1;
                end
            end
        end
    end

    // Divide by 1000 as a multiply by the reciprocal and a shift: the product is
    // registered in prod_reg, then the quotient is taken into the result register.
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            o_state_reg <= cur_next;
            o_drive_reg <= drive_next;
            o_ok_reg    <= ok;
            o_zw_reg    <= zw;
            o_zone_reg  <= new_zone;
            o_err_reg   <= err_next;
            o_done_reg  <= done;
            o_dur_reg   <= '0;
            div_q_reg   <= dur_ms;
        end
        else if (phase_mode_reg == PH_DIV)
        begin
            if (!div_cnt_reg)
            begin
                prod_reg <= 61'(div_q_reg) * 61'(MS_RECIP);
            end
            else
            begin
                o_dur_reg <= prod_reg[MS_RECIP_SHIFT +: 16];
            end
        end
    end

    assign out_valid          = ov_reg;
    assign machine_state      = o_state_reg;
    assign motor_drive        = o_drive_reg;
    assign request_accepted   = o_ok_reg;
    assign zone_write         = o_zw_reg;
    assign zone_value         = o_zone_reg;
    assign error_code         = o_err_reg;
    assign cycle_done         = o_done_reg;
    assign cycle_duration_sec = o_dur_reg;

endmodule

### rtl/rccc_checker.sv
// Port-level checks on the result channel of the cleaning-cycle controller.
// Depends on rccc_pkg; bound to rotary_cleaning_cycle_controller below.
module rccc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  machine_state,
    input logic [1:0]  motor_drive,
    input logic [2:0]  zone_value,
    input logic [1:0]  error_code,
    input logic        cycle_done,
    input logic [15:0] cycle_duration_sec
);
    import rccc_pkg::*;

    // A held result keeps its state and duration.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(machine_state)
            && $stable(cycle_duration_sec))
        else $error("stalled result changed");

    // A duration is only reported with a finished cycle.
    a_dur: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cycle_done |-> cycle_duration_sec == 16'd0)
        else $error("duration without finished cycle");

    // An error code is only held while in the error state.
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> machine_state == S_ERROR
            && motor_drive == D_STOP)
        else $error("error code outside error state");

    // Safe states stop the drum and report the safe zone.
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (machine_state == S_IDLE || machine_state == S_PAUSED)
            |-> motor_drive == D_STOP && zone_value == Z_SAFE)
        else $error("drum moving in a safe state");

endmodule

bind rotary_cleaning_cycle_controller rccc_checker u_rccc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .machine_state      (machine_state),
    .motor_drive        (motor_drive),
    .zone_value         (zone_value),
    .error_code         (error_code),
    .cycle_done         (cycle_done),
    .cycle_duration_sec (cycle_duration_sec)
);

### tb/tb.sv
// Self-checking testbench of the drum cleaning-cycle controller.
// Depends on rccc_pkg and rotary_cleaning_cycle_controller; drives requests and checks every result.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rccc_pkg::*;

    // Timing constants that match the block's parameter defaults.
    localparam int BACK_OVERSHOOT_SEC = 2;
    localparam int MANUAL_RESUME_SEC  = 60;
    localparam int PINCH_RESUME_SEC   = 10;

    typedef struct packed {
        logic [3:0]  state;
        logic [1:0]  drive;
        logic        accepted;
        logic        zwrite;
        logic [2:0]  zone;
        logic [1:0]  err;
        logic        done;
        logic [15:0] secs;
    } drum_result_t;

    typedef struct {
        logic [2:0]  act;
        logic [31:0] ms;
        logic [4:0]  sense;   // cat, scale, presence, home, dump
        logic [2:0]  zone;
        bit          typed;
        logic [3:0]  state;
        logic [1:0]  drive;
        logic        accepted;
        logic [1:0]  err;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] action = ACT_TICK;
    logic [31:0] now_ms = '0;
    logic cat_switch = 1'b0, cat_on_scale = 1'b0, presence_seen = 1'b0;
    logic at_home = 1'b0, at_dump = 1'b0;
    logic [2:0] saved_zone = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] machine_state;
    logic [1:0] motor_drive;
    logic request_accepted, zone_write, cycle_done;
    logic [2:0] zone_value;
    logic [1:0] error_code;
    logic [15:0] cycle_duration_sec;

    rotary_cleaning_cycle_controller u_top (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor copy of the configuration and of the controller state.
    logic [15:0] p_timeout;
    logic [7:0]  p_cat_min, p_wait_min, p_dump_sec, p_level_sec, p_empty_sec;
    logic        p_weight, p_pres;
    logic [3:0]  d_state, d_paused_from;
    logic [31:0] d_phase_ms, d_cycle_ms, d_timed_ms, d_enter_ms, d_left_ms, d_pause_ms;
    logic        d_armed, d_manual, d_resetting;
    logic [2:0]  d_saved_zone;
    logic [1:0]  d_drive, d_err;
    logic        r_zw, r_done;
    logic [15:0] r_secs;

    drum_result_t expected_results[$];
    int failures = 0, n_items = 0, n_results = 0, n_cycles = 0;
    bit quiet = 0;

    function automatic logic [2:0] zone_for(input logic [3:0] s);
        case (s)
            S_CCW, S_EMPTY:     return Z_OUT;
            S_DPAUSE, S_EPAUSE: return Z_DUMP;
            S_CW:               return Z_RETURN;
            S_LOVER, S_LRET:    return Z_PAST_CW;
            S_LBOVER, S_LBRET:  return Z_PAST_CC;
            S_RESET, S_BOOT:    return Z_UNKNOWN;
            default:            return Z_SAFE;
        endcase
    endfunction

    task automatic clear_drum();
        d_state = S_IDLE; d_paused_from = S_IDLE;
        d_phase_ms = 0; d_cycle_ms = 0; d_timed_ms = 0;
        d_enter_ms = 0; d_left_ms = 0; d_pause_ms = 0;
        d_armed = 0; d_manual = 0; d_resetting = 0;
        d_saved_zone = Z_SAFE; d_drive = D_STOP; d_err = ERR_NONE;
    endtask

    task automatic move_to(input logic [3:0] nxt);
        logic [2:0] z;
        if (nxt != d_state)
        begin
            d_state = nxt;
            z = zone_for(nxt);
            if (z != d_saved_zone)
            begin
                d_saved_zone = z;
                r_zw = 1;
            end
        end
    endtask

    task automatic trip(input logic [1:0] code);
        d_err = code;
        d_drive = D_STOP;
        move_to(S_ERROR);
    endtask

    task automatic resume_drum(input logic [31:0] t);
        d_phase_ms = t;
        case (d_paused_from)
            S_CCW, S_EMPTY:     d_drive = D_CCW;
            S_DPAUSE, S_EPAUSE: d_timed_ms = t;
            S_CW, S_RESET:      d_drive = D_CW;
            S_LOVER:            begin d_drive = D_CW; d_timed_ms = t; end
            S_LRET:             begin d_drive = D_CCW; d_armed = 0; end
            S_LBOVER:           begin d_drive = D_CCW; d_timed_ms = t; end
            S_LBRET:            begin d_drive = D_CW; d_armed = 0; end
            default: ;
        endcase
        move_to(d_paused_from);
    endtask

    task automatic finish_cycle(input logic [31:0] t);
        logic [31:0] q;
        d_drive = D_STOP;
        if (!d_resetting)
        begin
            q = (t - d_cycle_ms) / 32'd1000;
            r_done = 1;
            r_secs = q[15:0];
        end
        d_resetting = 0;
        move_to(S_IDLE);
    endtask

    task automatic timed_phase(input logic [31:0] t, input logic [3:0] nxt);
        d_timed_ms = t;
        d_phase_ms = t;
        move_to(nxt);
    endtask

    task automatic tick_drum(input logic [31:0] t, input logic [4:0] s);
        logic cat, scale, pres, home, dump, still;
        logic [31:0] grace;
        {cat, scale, pres, home, dump} = s;
        still = cat || (p_weight && scale) || (p_pres && pres);
        case (d_state)
            S_IDLE:
                if (cat || scale || pres)
                begin
                    d_enter_ms = t;
                    move_to(S_CAT);
                end
            S_CAT:
                if (!still || (t - d_enter_ms) > 32'(p_cat_min) * 32'd60000)
                begin
                    d_left_ms = t;
                    move_to(S_WAIT);
                end
            S_WAIT:
                if (still)
                begin
                    d_enter_ms = t;
                    move_to(S_CAT);
                end
                else if (t - d_left_ms >= 32'(p_wait_min) * 32'd60000)
                begin
                    d_resetting = 0; d_drive = D_CCW;
                    d_cycle_ms = t; d_phase_ms = t;
                    move_to(S_CCW);
                end
            S_PAUSED:
            begin
                grace = (d_manual ? 32'(MANUAL_RESUME_SEC) : 32'(PINCH_RESUME_SEC)) * 32'd1000;
                if (t - d_pause_ms >= grace)
                begin
                    if (!cat) resume_drum(t);
                    else trip(d_manual ? ERR_MANUAL : ERR_PINCH);
                end
            end
            S_ERROR: ;
            default:
            begin
                // Every motion state is guarded by the watchdog and the pinch pause first.
                if (t - d_phase_ms > 32'(p_timeout) * 32'd1000)
                    trip(ERR_WDOG);
                else if (cat)
                begin
                    d_drive = D_STOP;
                    d_paused_from = d_state;
                    d_pause_ms = t;
                    d_manual = 0;
                    move_to(S_PAUSED);
                end
                else
                    case (d_state)
                        S_CCW:
                            if (dump)
                            begin
                                d_drive = D_STOP;
                                timed_phase(t, S_DPAUSE);
                            end
                        S_DPAUSE:
                            if (t - d_timed_ms >= 32'(p_dump_sec) * 32'd1000)
                            begin
                                d_drive = D_CW; d_phase_ms = t;
                                move_to(S_CW);
                            end
                        S_CW:
                            if (home)
                            begin
                                if (p_level_sec == 0) finish_cycle(t);
                                else timed_phase(t, S_LOVER);
                            end
                        S_LOVER:
                            if (t - d_timed_ms >= 32'(p_level_sec) * 32'd1000)
                            begin
                                d_drive = D_CCW; d_phase_ms = t; d_armed = 0;
                                move_to(S_LRET);
                            end
                        S_LRET:
                            if (!d_armed)
                            begin
                                if (!home) d_armed = 1;
                            end
                            else if (home)
                                timed_phase(t, S_LBOVER);
                        S_LBOVER:
                            if (t - d_timed_ms >= 32'(BACK_OVERSHOOT_SEC) * 32'd1000)
                            begin
                                d_drive = D_CW; d_phase_ms = t; d_armed = 0;
                                move_to(S_LBRET);
                            end
                        S_LBRET:
                            if (!d_armed)
                            begin
                                if (!home) d_armed = 1;
                            end
                            else if (home)
                                finish_cycle(t);
                        S_EMPTY:
                            if (dump)
                            begin
                                d_drive = D_STOP;
                                timed_phase(t, S_EPAUSE);
                            end
                        S_EPAUSE:
                            if (t - d_timed_ms >= 32'(p_empty_sec) * 32'd1000)
                            begin
                                d_phase_ms = t;
                                move_to(S_RESET);
                            end
                        S_RESET:
                            if (home)
                            begin
                                d_drive = D_STOP; d_resetting = 0;
                                move_to(S_IDLE);
                            end
                            else if (t - d_phase_ms > 32'd1000)
                                d_drive = D_CW;
                        S_BOOT:
                            if (home)
                            begin
                                d_drive = D_STOP;
                                move_to(S_IDLE);
                            end
                        default: ;
                    endcase
            end
        endcase
    endtask

    task automatic boot_drum(input logic [31:0] t, input logic home, input logic dump,
                             input logic [2:0] zsaved);
        clear_drum();
        d_saved_zone = (zsaved > Z_UNKNOWN) ? Z_UNKNOWN : zsaved;
        if (home)
        begin
            if (d_saved_zone != Z_SAFE)
            begin
                d_saved_zone = Z_SAFE;
                r_zw = 1;
            end
        end
        else
        begin
            d_phase_ms = t; d_cycle_ms = t;
            if (d_saved_zone >= Z_OUT && d_saved_zone <= Z_PAST_CC)
            begin
                d_drive = (d_saved_zone == Z_PAST_CW) ? D_CCW : D_CW;
                move_to(S_BOOT);
            end
            else
            begin
                d_resetting = 1;
                if (dump)
                begin
                    d_timed_ms = t; d_drive = D_STOP;
                    move_to(S_DPAUSE);
                end
                else
                begin
                    d_drive = D_CCW;
                    move_to(S_CCW);
                end
            end
        end
    endtask

    // Works out the result of one accepted request and returns it.
    task automatic predict_drum(input logic [2:0] act, input logic [31:0] t,
                                input logic [4:0] s, input logic [2:0] zsaved,
                                output drum_result_t r);
        logic ok;
        logic [3:0] prev;
        ok = 1; r_zw = 0; r_done = 0; r_secs = 0;
        case (act)
            ACT_TICK: tick_drum(t, s);
            ACT_CYCLE, ACT_EMPTY:
                if (d_state != S_IDLE) ok = 0;
                else
                begin
                    d_resetting = 0; d_drive = D_CCW;
                    d_cycle_ms = t; d_phase_ms = t;
                    move_to(act == ACT_CYCLE ? S_CCW : S_EMPTY);
                end
            ACT_RESET:
            begin
                prev = d_state;
                d_drive = D_STOP; d_err = ERR_NONE;
                if (!(prev == S_ERROR || prev == S_PAUSED || prev == S_EMPTY ||
                      prev == S_EPAUSE || prev == S_DPAUSE || prev == S_RESET ||
                      (prev >= S_LOVER && prev <= S_LBRET)))
                    ok = 0;
                else if (s[1])
                begin
                    d_resetting = 0;
                    move_to(S_IDLE);
                end
                else
                begin
                    d_resetting = 1; d_cycle_ms = t; d_phase_ms = t;
                    if (s[0])
                    begin
                        d_timed_ms = t;
                        move_to(S_DPAUSE);
                    end
                    else
                    begin
                        d_drive = D_CCW;
                        move_to(S_CCW);
                    end
                end
            end
            ACT_HOME:
                if (d_state == S_IDLE) ok = 0;
                else
                begin
                    d_drive = D_STOP; d_err = ERR_NONE; d_resetting = 1;
                    d_cycle_ms = t; d_phase_ms = t;
                    if (s[1])
                    begin
                        d_resetting = 0;
                        move_to(S_IDLE);
                    end
                    else
                    begin
                        d_drive = D_CW;
                        move_to(S_CW);
                    end
                end
            ACT_PAUSE:
                if (d_state < S_CCW || d_state > S_BOOT) ok = 0;
                else
                begin
                    d_drive = D_STOP; d_paused_from = d_state;
                    d_pause_ms = t; d_manual = 1;
                    move_to(S_PAUSED);
                end
            ACT_RESUME:
                if (d_state != S_PAUSED) ok = 0;
                else resume_drum(t);
            default: boot_drum(t, s[1], s[0], zsaved);
        endcase
        r = '{d_state, d_drive, ok, r_zw, zone_for(d_state), d_err, r_done, r_secs};
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_TIMEOUT:  p_timeout = val;
            CFG_CAT_MIN:  p_cat_min = val[7:0];
            CFG_WAIT_MIN: p_wait_min = val[7:0];
            CFG_DUMP:     p_dump_sec = val[7:0];
            CFG_LEVEL:    p_level_sec = val[7:0];
            CFG_EPAUSE:   p_empty_sec = val[7:0];
            CFG_WEIGHT:   p_weight = val[0];
            default:      p_pres = val[0];
        endcase
    endtask

    // Sends one request; the expectation is queued at the edge that accepts it.
    task automatic send_request(input stim_row_t row);
        drum_result_t r;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid = 1'b1;
        action = row.act; now_ms = row.ms;
        {cat_switch, cat_on_scale, presence_seen, at_home, at_dump} = row.sense;
        saved_zone = row.zone;
        do @(posedge clk); while (in_stall);
        predict_drum(row.act, row.ms, row.sense, row.zone, r);
        if (row.typed)
        begin
            r.state = row.state; r.drive = row.drive;
            r.accepted = row.accepted; r.err = row.err;
            r.zone = zone_for(row.state);
        end
        expected_results.push_back(r);
        n_items++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        // A finished cycle keeps the divider busy.
        repeat (50) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
        if (e !== a)
        begin
            $display("%0t: mismatch in %s: expected %0d, actual %0d", $realtime, name, e, a);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        drum_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding, state %0d",
                         $realtime, machine_state);
                failures++;
            end
            else
            begin
                e = expected_results.pop_front();
                n_results++;
                if (cycle_done) n_cycles++;
                check_field("machine_state", 16'(e.state), 16'(machine_state));
                check_field("motor_drive", 16'(e.drive), 16'(motor_drive));
                check_field("request_accepted", 16'(e.accepted), 16'(request_accepted));
                check_field("zone_write", 16'(e.zwrite), 16'(zone_write));
                check_field("zone_value", 16'(e.zone), 16'(zone_value));
                check_field("error_code", 16'(e.err), 16'(error_code));
                check_field("cycle_done", 16'(e.done), 16'(cycle_done));
                check_field("cycle_duration_sec", e.secs, cycle_duration_sec);
            end
        end
    end

    // Receiver stalls in bursts until the quiet stretch at the end.
    always @(negedge clk)
    begin
        if (quiet || !rst_n) out_stall = 1'b0;
        else if (out_stall) out_stall = ($urandom_range(0, 3) != 0);
        else out_stall = ($urandom_range(0, 9) == 0);
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        stim_row_t dir[$];
        stim_row_t row;
        logic [15:0] settings[5][8];
        logic [31:0] t;
        int k;
        settings = '{'{16'd5, 16'd1, 16'd0, 16'd1, 16'd1, 16'd2, 16'd1, 16'd0},
                     '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1},
                     '{16'd65535, 16'd255, 16'd255, 16'd255, 16'd255, 16'd255, 16'd1, 16'd1},
                     '{16'd3, 16'd2, 16'd1, 16'd2, 16'd0, 16'd1, 16'd0, 16'd0},
                     '{16'd10, 16'd1, 16'd0, 16'd3, 16'd2, 16'd3, 16'd1, 16'd1}};
        p_timeout = 120; p_cat_min = 30; p_wait_min = 7; p_dump_sec = 5;
        p_level_sec = 2; p_empty_sec = 30; p_weight = 0; p_pres = 0;
        clear_drum();

        // Directed rows run with the reset defaults: a full cleaning cycle with levelling,
        // pinch pause into error, manual pause, boot from an unknown zone, watchdog at wrap.
        dir = '{
            '{ACT_TICK,   32'd0,      5'b00000, 3'd0, 1, S_IDLE,   D_STOP, 1, ERR_NONE},
            '{ACT_RESUME, 32'd10,     5'b00000, 3'd0, 1, S_IDLE,   D_STOP, 0, ERR_NONE},
            '{ACT_PAUSE,  32'd20,     5'b00000, 3'd0, 1, S_IDLE,   D_STOP, 0, ERR_NONE},
            '{ACT_HOME,   32'd30,     5'b00010, 3'd0, 1, S_IDLE,   D_STOP, 0, ERR_NONE},
            '{ACT_RESET,  32'd40,     5'b00011, 3'd0, 1, S_IDLE,   D_STOP, 0, ERR_NONE},
            '{ACT_TICK,   32'd1000,   5'b10000, 3'd0, 1, S_CAT,    D_STOP, 1, ERR_NONE},
            '{ACT_TICK,   32'd2000,   5'b01100, 3'd0, 1, S_WAIT,   D_STOP, 1, ERR_NONE},
            '{ACT_TICK,   32'd422000, 5'b00000, 3'd0, 1, S_CCW,    D_CCW,  1, ERR_NONE},
            '{ACT_TICK,   32'd423000, 5'b10000, 3'd0, 1, S_PAUSED, D_STOP, 1, ERR_NONE},
            '{ACT_TICK,   32'd433000, 5'b10000, 3'd0, 1, S_ERROR,  D_STOP, 1, ERR_PINCH},
            '{ACT_TICK,   32'd434000, 5'b00000, 3'd0, 0, 0, 0, 0, 0},
            '{ACT_HOME,   32'd435000, 5'b00010, 3'd0, 1, S_IDLE,   D_STOP, 1, ERR_NONE},
            '{ACT_CYCLE,  32'd500000, 5'b00000, 3'd0, 1, S_CCW,    D_CCW,  1, ERR_NONE},
            '{ACT_TICK,   32'd501000, 5'b00001, 3'd0, 1, S_DPAUSE, D_STOP, 1, ERR_NONE},
            '{ACT_PAUSE,  32'd502000, 5'b00000, 3'd0, 1, S_PAUSED, D_STOP, 1, ERR_NONE},
            '{ACT_RESUME, 32'd503000, 5'b00000, 3'd0, 1, S_DPAUSE, D_STOP, 1, ERR_NONE},
            '{ACT_TICK,   32'd508000, 5'b00000, 3'd0, 1, S_CW,     D_CW,   1, ERR_NONE},
            '{ACT_TICK,   32'd509000, 5'b00010, 3'd0, 0, 0, 0, 0, 0},
            '{ACT_TICK,   32'd511000, 5'b00010, 3'd0, 0, 0, 0, 0, 0},
            '{ACT_TICK,   32'd511500, 5'b00000, 3'd0, 0, 0, 0, 0, 0},
            '{ACT_TICK,   32'd512000, 5'b00010, 3'd0, 0, 0, 0, 0, 0},
            '{ACT_TICK,   32'd514000, 5'b00000, 3'd0, 0, 0, 0, 0, 0},
            '{ACT_TICK,   32'd514500, 5'b00000, 3'd0, 0, 0, 0, 0, 0},
            '{ACT_TICK,   32'd515000, 5'b00010, 3'd0, 1, S_IDLE,   D_STOP, 1, ERR_NONE},
            '{ACT_BOOT,   32'd600000, 5'b00000, 3'd7, 1, S_CCW,    D_CCW,  1, ERR_NONE},
            '{ACT_EMPTY,  32'd600100, 5'b00000, 3'd0, 1, S_CCW,    D_CCW,  0, ERR_NONE},
            '{ACT_TICK,   32'hFFFFFFFF, 5'b00000, 3'd0, 1, S_ERROR, D_STOP, 1, ERR_WDOG},
            '{ACT_RESET,  32'd0,      5'b00010, 3'd0, 1, S_IDLE,   D_STOP, 1, ERR_NONE}};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (dir[i]) send_request(dir[i]);
        drain_results();

        t = 32'd0;
        for (int ph = 0; ph < 5; ph++)
        begin
            for (int r = 0; r < 8; r++) write_reg(3'(r), settings[ph][r]);
            if (ph == 2) t = 32'hFFF0_0000;   // run this phase across the timestamp wrap
            for (int n = 0; n < 340; n++)
            begin
                if (ph == 4 && n == 170) quiet = 1;
                k = $urandom_range(0, 199);
                if (k == 0) t = $urandom;
                else if (k < 12) t += $urandom_range(0, 900000);
                else t += $urandom_range(0, 2500);
                row = '{ACT_TICK, t, 5'b0, 3'($urandom_range(0, 7)), 0, 0, 0, 0, 0};
                row.sense = {$urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0,
                             $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0,
                             $urandom_range(0, 2) == 0};
                k = $urandom_range(0, 99);
                if (k >= 75) row.act = (k >= 98) ? ACT_BOOT : 3'($urandom_range(1, 6));
                send_request(row);
            end
            drain_results();
        end

        $display("Sent %0d requests through five register settings, %0d results checked,",
                 n_items, n_results);
        $display("%0d cleaning cycles finished.", n_cycles);
        if (failures == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
